### rtl/core/aqe_pkg.sv
// ----------------------------------------------------------------------------
// aqe_pkg
// shared types and constants of the swap quote engine
// ----------------------------------------------------------------------------
package aqe_pkg;

    localparam int unsigned WORD_W = 64;
    localparam int unsigned FEE_W  = 14;

    localparam logic [FEE_W-1:0]  BPS_ONE   = 14'd10000;
    localparam logic [FEE_W-1:0]  FEE_RESET = 14'd30;
    localparam logic [WORD_W-1:0] PRICE_ONE = 64'd1000000000000000000;

    typedef enum logic [1:0] {
        REQ_OUT_QUOTE  = 2'd0,
        REQ_IN_QUOTE   = 2'd1,
        REQ_PRICE      = 2'd2,
        REQ_SWAP_CHECK = 2'd3
    } req_t;

    // operand flags worked out on entry
    typedef struct packed {
        logic in_zero;
        logic out_zero;
        logic rin_zero;
        logic rout_zero;
        logic out_ge;
    } flags_t;

    // sideband that rides along a divider chain
    typedef struct packed {
        req_t              kind;
        logic [WORD_W-1:0] word;
        logic              zero;
        logic              ok;
    } side_t;

    // contents of one divider cell
    typedef struct packed {
        logic [WORD_W-1:0] rem;
        logic [WORD_W-1:0] quo;
        logic [WORD_W-1:0] dvs;
        side_t             side;
    } div_data_t;

endpackage

### rtl/core/aqe_div_cell.sv
// ----------------------------------------------------------------------------
// aqe_div_cell
// one restoring division step, registered
// ----------------------------------------------------------------------------
module aqe_div_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_v,
    input  aqe_pkg::div_data_t  in_d,
    output logic                out_v,
    output aqe_pkg::div_data_t  out_d
);

    logic                     v_reg;
    aqe_pkg::div_data_t       d_reg;
    aqe_pkg::div_data_t       d_next;
    logic [aqe_pkg::WORD_W:0] trial;
    logic [aqe_pkg::WORD_W:0] diff;
    logic                     take;

    always_comb
    begin
        trial  = {in_d.rem, in_d.quo[aqe_pkg::WORD_W-1]};
        diff   = trial - {1'b0, in_d.dvs};
        take   = (trial >= {1'b0, in_d.dvs});
        d_next = in_d;
        d_next.rem = take ? diff[aqe_pkg::WORD_W-1:0] : trial[aqe_pkg::WORD_W-1:0];
        d_next.quo = {in_d.quo[aqe_pkg::WORD_W-2:0], take};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else if (en)
        begin
            v_reg <= in_v;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_reg <= d_next;
        end
    end

    assign out_v = v_reg;
    assign out_d = d_reg;

endmodule

### rtl/core/aqe_div_chain.sv
// ----------------------------------------------------------------------------
// aqe_div_chain
// row of division cells, one quotient bit per cell
// ----------------------------------------------------------------------------
module aqe_div_chain (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_v,
    input  logic [aqe_pkg::WORD_W-1:0]    dividend,
    input  logic [aqe_pkg::WORD_W-1:0]    divisor,
    input  aqe_pkg::side_t                in_side,
    output logic                          out_v,
    output logic [aqe_pkg::WORD_W-1:0]    quotient,
    output aqe_pkg::side_t                out_side
);

    logic               v [0:aqe_pkg::WORD_W];
    aqe_pkg::div_data_t d [0:aqe_pkg::WORD_W];

    always_comb
    begin
        v[0]      = in_v;
        d[0].rem  = '0;
        d[0].quo  = dividend;
        d[0].dvs  = divisor;
        d[0].side = in_side;
    end

    for (genvar i = 0; i < aqe_pkg::WORD_W; i++)
    begin : g_cell
        aqe_div_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .en    (en),
            .in_v  (v[i]),
            .in_d  (d[i]),
            .out_v (v[i+1]),
            .out_d (d[i+1])
        );
    end

    assign out_v    = v[aqe_pkg::WORD_W];
    assign quotient = d[aqe_pkg::WORD_W].quo;
    assign out_side = d[aqe_pkg::WORD_W].side;

endmodule

### rtl/core/amm_swap_quote_engine.sv
// ----------------------------------------------------------------------------
// amm_swap_quote_engine
// constant-product pool quote unit with a fee in basis points
//
//   channel | signals                                   | transfer
//   in      | req_type in_amount out_amount reserve_*   | in_valid & in_ready
//   out     | amount swap_ok                            | out_valid & out_ready
//   cfg     | cfg_wdata (fee_bps)                       | cfg_we
//
// one request per cycle unless the pipeline holds; the path runs through five
// operand and multiply stages, a 64-cell divider chain, two price multiply
// stages, a second 64-cell chain and the output register
// reset clears every stage valid and sets fee_bps to 30
// the whole pipeline holds while a result waits and out_ready is low
// ----------------------------------------------------------------------------
module amm_swap_quote_engine (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [aqe_pkg::FEE_W-1:0]           cfg_wdata,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [1:0]                          req_type,
    input  logic [63:0]                         in_amount,
    input  logic [63:0]                         out_amount,
    input  logic [63:0]                         reserve_in,
    input  logic [63:0]                         reserve_out,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [63:0]                         amount,
    output logic                                swap_ok
);

    logic en;
    logic [13:0] fee_reg;
    logic [13:0] ff;

    // stage 1
    logic v1_reg;
    aqe_pkg::req_t k1_reg;
    aqe_pkg::flags_t f1_reg;
    logic [63:0] in1_reg, out1_reg, rin1_reg, rout1_reg;
    logic [13:0] ff1_reg;
    // stage 2
    logic v2_reg;
    aqe_pkg::req_t k2_reg;
    aqe_pkg::flags_t f2_reg;
    logic [63:0] in2_reg, rout2_reg, wf2_reg, rk2_reg, denin2_reg, nout2_reg;
    logic [63:0] rr00_reg, rr01_reg, rr10_reg, rr11_reg, ro00_reg, ro01_reg, ro10_reg;
    logic [63:0] dout;
    // stage 3
    logic v3_reg;
    aqe_pkg::req_t k3_reg;
    aqe_pkg::flags_t f3_reg;
    logic [63:0] in3_reg, den3_reg, denin3_reg, nout3_reg, ro3_reg;
    logic [63:0] wr00_reg, wr01_reg, wr10_reg;
    logic [127:0] rr3_reg;
    // stage 4
    logic v4_reg;
    aqe_pkg::req_t k4_reg;
    aqe_pkg::flags_t f4_reg;
    logic [63:0] in4_reg, den4_reg, denin4_reg, numout4_reg, numin4_reg, bh4_reg;
    logic [77:0] bl4_reg;
    logic [63:0] af00_reg, af01_reg, af10_reg, af11_reg;
    // stage 5
    logic v5_reg;
    aqe_pkg::req_t k5_reg;
    aqe_pkg::flags_t f5_reg;
    logic [63:0] in5_reg, dvd5_reg, dvs5_reg;
    logic [127:0] before5_reg, after5_reg;
    logic zero5;
    // chain 1
    aqe_pkg::side_t side1_in, side1_out;
    logic c1_v;
    logic [63:0] q1;
    // stage 7
    logic v7_reg;
    aqe_pkg::side_t s7_reg;
    logic [63:0] in7_reg, pp00_reg, pp01_reg, pp10_reg;
    aqe_pkg::side_t s7_next;
    // stage 8
    logic v8_reg;
    aqe_pkg::side_t s8_reg;
    logic [63:0] in8_reg, prod8_reg;
    // chain 2
    aqe_pkg::side_t side2_out;
    logic c2_v;
    logic [63:0] q2;
    // output
    logic out_v_reg, ok_reg;
    logic [63:0] amt_reg, amt_next;

    assign en       = !out_v_reg || out_ready;
    assign in_ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fee_reg <= aqe_pkg::FEE_RESET;
        end
        else if (cfg_we)
        begin
            fee_reg <= cfg_wdata;
        end
    end

    assign ff = (fee_reg > aqe_pkg::BPS_ONE) ? 14'd0 : aqe_pkg::BPS_ONE - fee_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            v3_reg    <= 1'b0;
            v4_reg    <= 1'b0;
            v5_reg    <= 1'b0;
            v7_reg    <= 1'b0;
            v8_reg    <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg    <= in_valid;
            v2_reg    <= v1_reg;
            v3_reg    <= v2_reg;
            v4_reg    <= v3_reg;
            v5_reg    <= v4_reg;
            v7_reg    <= c1_v;
            v8_reg    <= v7_reg;
            out_v_reg <= c2_v;
        end
    end

    assign dout = rout1_reg - out1_reg;

    always_comb
    begin
        if (k5_reg == aqe_pkg::REQ_IN_QUOTE)
        begin
            zero5 = f5_reg.out_zero | f5_reg.rin_zero | f5_reg.rout_zero | f5_reg.out_ge
                    | (dvs5_reg == 64'd0);
        end
        else
        begin
            zero5 = f5_reg.in_zero | f5_reg.rin_zero | f5_reg.rout_zero
                    | (dvs5_reg == 64'd0);
        end
    end

    always_comb
    begin
        side1_in.kind = k5_reg;
        side1_in.word = in5_reg;
        side1_in.zero = zero5;
        side1_in.ok   = !(f5_reg.in_zero | f5_reg.out_zero | f5_reg.out_ge)
                        && (after5_reg >= before5_reg);
    end

    always_comb
    begin
        s7_next = side1_out;
        if (side1_out.kind == aqe_pkg::REQ_IN_QUOTE)
        begin
            s7_next.word = side1_out.zero ? 64'd0 : q1 + 64'd1;
        end
        else
        begin
            s7_next.word = side1_out.zero ? 64'd0 : q1;
        end
        s7_next.zero = side1_out.zero | (q1 == 64'd0);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // operand capture
            k1_reg           <= aqe_pkg::req_t'(req_type);
            in1_reg          <= in_amount;
            out1_reg         <= out_amount;
            rin1_reg         <= reserve_in;
            rout1_reg        <= reserve_out;
            ff1_reg          <= ff;
            f1_reg.in_zero   <= (in_amount == 64'd0);
            f1_reg.out_zero  <= (out_amount == 64'd0);
            f1_reg.rin_zero  <= (reserve_in == 64'd0);
            f1_reg.rout_zero <= (reserve_out == 64'd0);
            f1_reg.out_ge    <= (out_amount >= reserve_out);

            // narrow products and partial products
            k2_reg     <= k1_reg;
            f2_reg     <= f1_reg;
            in2_reg    <= in1_reg;
            rout2_reg  <= rout1_reg;
            wf2_reg    <= in1_reg * {50'd0, ff1_reg};
            rk2_reg    <= rin1_reg * {50'd0, aqe_pkg::BPS_ONE};
            denin2_reg <= dout * {50'd0, ff1_reg};
            nout2_reg  <= dout * {50'd0, aqe_pkg::BPS_ONE};
            rr00_reg   <= {32'd0, rin1_reg[31:0]} * {32'd0, rout1_reg[31:0]};
            rr01_reg   <= {32'd0, rin1_reg[31:0]} * {32'd0, rout1_reg[63:32]};
            rr10_reg   <= {32'd0, rin1_reg[63:32]} * {32'd0, rout1_reg[31:0]};
            rr11_reg   <= {32'd0, rin1_reg[63:32]} * {32'd0, rout1_reg[63:32]};
            ro00_reg   <= {32'd0, rin1_reg[31:0]} * {32'd0, out1_reg[31:0]};
            ro01_reg   <= {32'd0, rin1_reg[31:0]} * {32'd0, out1_reg[63:32]};
            ro10_reg   <= {32'd0, rin1_reg[63:32]} * {32'd0, out1_reg[31:0]};

            // sums of partials, denominator
            k3_reg     <= k2_reg;
            f3_reg     <= f2_reg;
            in3_reg    <= in2_reg;
            den3_reg   <= rk2_reg + wf2_reg;
            denin3_reg <= denin2_reg;
            nout3_reg  <= nout2_reg;
            ro3_reg    <= ro00_reg + {ro01_reg[31:0] + ro10_reg[31:0], 32'd0};
            rr3_reg    <= {64'd0, rr00_reg} + {32'd0, rr01_reg, 32'd0}
                          + {32'd0, rr10_reg, 32'd0} + {rr11_reg, 64'd0};
            wr00_reg   <= {32'd0, wf2_reg[31:0]} * {32'd0, rout2_reg[31:0]};
            wr01_reg   <= {32'd0, wf2_reg[31:0]} * {32'd0, rout2_reg[63:32]};
            wr10_reg   <= {32'd0, wf2_reg[63:32]} * {32'd0, rout2_reg[31:0]};

            // numerators, invariant partials
            k4_reg      <= k3_reg;
            f4_reg      <= f3_reg;
            in4_reg     <= in3_reg;
            den4_reg    <= den3_reg;
            denin4_reg  <= denin3_reg;
            numout4_reg <= wr00_reg + {wr01_reg[31:0] + wr10_reg[31:0], 32'd0};
            numin4_reg  <= ro3_reg * {50'd0, aqe_pkg::BPS_ONE};
            bl4_reg     <= {14'd0, rr3_reg[63:0]} * {64'd0, aqe_pkg::BPS_ONE};
            bh4_reg     <= rr3_reg[127:64] * {50'd0, aqe_pkg::BPS_ONE};
            af00_reg    <= {32'd0, den3_reg[31:0]} * {32'd0, nout3_reg[31:0]};
            af01_reg    <= {32'd0, den3_reg[31:0]} * {32'd0, nout3_reg[63:32]};
            af10_reg    <= {32'd0, den3_reg[63:32]} * {32'd0, nout3_reg[31:0]};
            af11_reg    <= {32'd0, den3_reg[63:32]} * {32'd0, nout3_reg[63:32]};

            // operand select, invariant sums
            k5_reg      <= k4_reg;
            f5_reg      <= f4_reg;
            in5_reg     <= in4_reg;
            dvd5_reg    <= (k4_reg == aqe_pkg::REQ_IN_QUOTE) ? numin4_reg : numout4_reg;
            dvs5_reg    <= (k4_reg == aqe_pkg::REQ_IN_QUOTE) ? denin4_reg : den4_reg;
            before5_reg <= {bh4_reg, 64'd0} + {50'd0, bl4_reg};
            after5_reg  <= {64'd0, af00_reg} + {32'd0, af01_reg, 32'd0}
                           + {32'd0, af10_reg, 32'd0} + {af11_reg, 64'd0};

            // price scaling
            s7_reg   <= s7_next;
            in7_reg  <= side1_out.word;
            pp00_reg <= {32'd0, q1[31:0]} * {32'd0, aqe_pkg::PRICE_ONE[31:0]};
            pp01_reg <= {32'd0, q1[31:0]} * {32'd0, aqe_pkg::PRICE_ONE[63:32]};
            pp10_reg <= {32'd0, q1[63:32]} * {32'd0, aqe_pkg::PRICE_ONE[31:0]};

            s8_reg    <= s7_reg;
            in8_reg   <= in7_reg;
            prod8_reg <= pp00_reg + {pp01_reg[31:0] + pp10_reg[31:0], 32'd0};

            amt_reg <= amt_next;
            ok_reg  <= (side2_out.kind == aqe_pkg::REQ_SWAP_CHECK) && side2_out.ok;
        end
    end

    aqe_div_chain u_div_quote (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_v     (v5_reg),
        .dividend (dvd5_reg),
        .divisor  (dvs5_reg),
        .in_side  (side1_in),
        .out_v    (c1_v),
        .quotient (q1),
        .out_side (side1_out)
    );

    aqe_div_chain u_div_price (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_v     (v8_reg),
        .dividend (prod8_reg),
        .divisor  (in8_reg),
        .in_side  (s8_reg),
        .out_v    (c2_v),
        .quotient (q2),
        .out_side (side2_out)
    );

    always_comb
    begin
        unique case (side2_out.kind)
            aqe_pkg::REQ_PRICE:      amt_next = side2_out.zero ? 64'd0 : q2;
            aqe_pkg::REQ_SWAP_CHECK: amt_next = 64'd0;
            default:                 amt_next = side2_out.word;
        endcase
    end

    assign out_valid = out_v_reg;
    assign amount    = amt_reg;
    assign swap_ok   = ok_reg;

endmodule
